// ----- src/su8v_pkg.sv -----
package su8v_pkg;

    // Byte-order mark that a payload must not start with
    localparam logic [7:0] MARK_BYTE_0 = 8'hef;
    localparam logic [7:0] MARK_BYTE_1 = 8'hbb;
    localparam logic [7:0] MARK_BYTE_2 = 8'hbf;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LOW  = 8'hc2;
    localparam logic [7:0] LEAD2_HIGH = 8'hdf;
    localparam logic [7:0] LEAD3_LOW  = 8'he0;
    localparam logic [7:0] LEAD3_HIGH = 8'hef;
    localparam logic [7:0] LEAD4_LOW  = 8'hf0;
    localparam logic [7:0] LEAD4_HIGH = 8'hf4;
    localparam logic [7:0] ASCII_HIGH = 8'h7f;

    // Code point limits
    localparam int CP_WIDTH = 21;
    localparam logic [CP_WIDTH-1:0] MIN_CLASS_2BYTE = 21'h000080;
    localparam logic [CP_WIDTH-1:0] MIN_CLASS_3BYTE = 21'h000800;
    localparam logic [CP_WIDTH-1:0] MIN_CLASS_4BYTE = 21'h010000;
    localparam logic [CP_WIDTH-1:0] MAX_CODE_POINT  = 21'h10ffff;
    localparam logic [CP_WIDTH-1:0] SURROGATE_LOW   = 21'h00d800;
    localparam logic [CP_WIDTH-1:0] SURROGATE_HIGH  = 21'h00dfff;

    // Sequence class codes
    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_2BYTE = 2'd1,
        CLASS_3BYTE = 2'd2,
        CLASS_4BYTE = 2'd3
    } seq_class_t;

endpackage

// ----- src/strict_utf8_validator_top.sv -----
// Channel   Direction  Handshake                   Payload
// byte      in         byte_valid / byte_ready     data_byte, byte_present, end_of_payload
// verdict   out        verdict_valid / verdict_ready  payload_ok
//
// One transaction is taken per cycle while byte_ready is high; the decode of a byte
// and the verdict on a final transaction are settled in the cycle of acceptance
// and the verdict appears in the output register in the following cycle.
// The output register frees itself in the cycle it is taken, so a stalled
// verdict holds byte_ready low only until verdict_ready returns.
// Reset (rst_n low, asynchronous) clears all decode state and the output slot.
module strict_utf8_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       byte_present,
    input  logic       end_of_payload,
    output logic       verdict_valid,
    input  logic       verdict_ready,
    output logic       payload_ok
);

    localparam int CPW = su8v_pkg::CP_WIDTH;

    logic [1:0]                 pending_reg, pending_next;
    logic [CPW-1:0]             acc_reg, acc_next;
    su8v_pkg::seq_class_t       class_reg, class_next;
    logic                       error_reg, error_next;
    logic [1:0]                 lead_pos_reg, lead_pos_next;
    logic                       mark_match_reg, mark_match_next;
    logic                       any_byte_reg, any_byte_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_ok_reg, out_ok_next;

    logic                       byte_fire;
    logic [7:0]                 mark_byte;
    logic [CPW-1:0]             shifted_acc;
    logic [CPW-1:0]             min_point;
    logic                       point_bad;
    logic                       verdict_ok;

    // The output slot accepts a new verdict when empty or being emptied.
    assign byte_ready = !out_valid_reg || verdict_ready;
    assign byte_fire  = byte_valid && byte_ready;

    assign verdict_valid = out_valid_reg;
    assign payload_ok    = out_ok_reg;

    // Expected byte of the byte-order mark at the current position.
    always_comb
    begin
        unique case (lead_pos_reg)
            2'd0:    mark_byte = su8v_pkg::MARK_BYTE_0;
            2'd1:    mark_byte = su8v_pkg::MARK_BYTE_1;
            default: mark_byte = su8v_pkg::MARK_BYTE_2;
        endcase
    end

    // Code point once this continuation byte is folded in, and its check.
    assign shifted_acc = {acc_reg[CPW-7:0], data_byte[5:0]};

    always_comb
    begin
        unique case (class_reg)
            su8v_pkg::CLASS_2BYTE: min_point = su8v_pkg::MIN_CLASS_2BYTE;
            su8v_pkg::CLASS_3BYTE: min_point = su8v_pkg::MIN_CLASS_3BYTE;
            default:               min_point = su8v_pkg::MIN_CLASS_4BYTE;
        endcase
    end

    assign point_bad = (shifted_acc < min_point)
                    || (shifted_acc > su8v_pkg::MAX_CODE_POINT)
                    || ((shifted_acc >= su8v_pkg::SURROGATE_LOW)
                        && (shifted_acc <= su8v_pkg::SURROGATE_HIGH));

    // Decode of one byte and the verdict on the final transaction.
    always_comb
    begin
        pending_next    = pending_reg;
        acc_next        = acc_reg;
        class_next      = class_reg;
        error_next      = error_reg;
        lead_pos_next   = lead_pos_reg;
        mark_match_next = mark_match_reg;
        any_byte_next   = any_byte_reg;
        out_valid_next  = out_valid_reg && !verdict_ready;
        out_ok_next     = out_ok_reg;
        verdict_ok      = 1'b0;

        if (byte_fire)
        begin
            if (byte_present)
            begin
                any_byte_next = 1'b1;

                // Track the byte-order mark over the first three bytes.
                if (lead_pos_reg != 2'd3)
                begin
                    if (mark_match_reg && (data_byte == mark_byte))
                    begin
                        if (lead_pos_reg == 2'd2)
                        begin
                            error_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mark_match_next = 1'b0;
                    end
                    lead_pos_next = lead_pos_reg + 2'd1;
                end

                // Decoding stops once an error has been recorded.
                if (!error_next)
                begin
                    if (pending_reg != 2'd0)
                    begin
                        if (data_byte[7:6] != 2'b10)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            acc_next     = shifted_acc;
                            pending_next = pending_reg - 2'd1;
                            if ((pending_reg == 2'd1) && point_bad)
                            begin
                                error_next = 1'b1;
                            end
                        end
                    end
                    else if (data_byte == 8'h00)
                    begin
                        error_next = 1'b1;
                    end
                    else if (data_byte <= su8v_pkg::ASCII_HIGH)
                    begin
                        // Single-byte character needs nothing further.
                    end
                    else if ((data_byte >= su8v_pkg::LEAD2_LOW)
                          && (data_byte <= su8v_pkg::LEAD2_HIGH))
                    begin
                        pending_next = 2'd1;
                        acc_next     = {{(CPW-5){1'b0}}, data_byte[4:0]};
                        class_next   = su8v_pkg::CLASS_2BYTE;
                    end
                    else if ((data_byte >= su8v_pkg::LEAD3_LOW)
                          && (data_byte <= su8v_pkg::LEAD3_HIGH))
                    begin
                        pending_next = 2'd2;
                        acc_next     = {{(CPW-4){1'b0}}, data_byte[3:0]};
                        class_next   = su8v_pkg::CLASS_3BYTE;
                    end
                    else if ((data_byte >= su8v_pkg::LEAD4_LOW)
                          && (data_byte <= su8v_pkg::LEAD4_HIGH))
                    begin
                        pending_next = 2'd3;
                        acc_next     = {{(CPW-3){1'b0}}, data_byte[2:0]};
                        class_next   = su8v_pkg::CLASS_4BYTE;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
            end

            // The final transaction yields the verdict and clears all state.
            if (end_of_payload)
            begin
                verdict_ok      = !error_next && any_byte_next && (pending_next == 2'd0);
                out_valid_next  = 1'b1;
                out_ok_next     = verdict_ok;
                pending_next    = 2'd0;
                acc_next        = '0;
                class_next      = su8v_pkg::CLASS_NONE;
                error_next      = 1'b0;
                lead_pos_next   = 2'd0;
                mark_match_next = 1'b1;
                any_byte_next   = 1'b0;
            end
        end
    end

    // State and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 2'd0;
            acc_reg        <= '0;
            class_reg      <= su8v_pkg::CLASS_NONE;
            error_reg      <= 1'b0;
            lead_pos_reg   <= 2'd0;
            mark_match_reg <= 1'b1;
            any_byte_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_ok_reg     <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            acc_reg        <= acc_next;
            class_reg      <= class_next;
            error_reg      <= error_next;
            lead_pos_reg   <= lead_pos_next;
            mark_match_reg <= mark_match_next;
            any_byte_reg   <= any_byte_next;
            out_valid_reg  <= out_valid_next;
            out_ok_reg     <= out_ok_next;
        end
    end

`ifndef SYNTHESIS
    // A held verdict must block new transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !verdict_ready) |-> !byte_ready)
        else $error("transaction accepted while verdict stalled");

    // State is clear after every final transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && end_of_payload) |=>
            ((pending_reg == 2'd0) && !error_reg && !any_byte_reg
             && (lead_pos_reg == 2'd0) && mark_match_reg))
        else $error("state not cleared after verdict");

    // Continuations are only pending inside a classified sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != 2'd0) |-> (class_reg != su8v_pkg::CLASS_NONE))
        else $error("pending continuations without a sequence class");

    // Byte position and byte-seen flag agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lead_pos_reg == 2'd0) |-> !any_byte_reg)
        else $error("byte recorded without position advance");
`endif

endmodule

// ----- tb/strict_utf8_verdict_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the validator, keeps its own decoder state and
// compares every verdict with the oldest verdict still owed.
module strict_utf8_verdict_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       byte_present,
    input  logic       end_of_payload,
    input  logic       verdict_valid,
    input  logic       verdict_ready,
    input  logic       payload_ok,
    output int         fail_count,
    output int         verdicts_waiting
);

    localparam int MAX_REPORTS = 10;
    localparam int CPW         = su8v_pkg::CP_WIDTH;

    // Decoder state of the payload currently being received.
    logic [1:0]           cont_left;
    logic [CPW-1:0]       code_point;
    su8v_pkg::seq_class_t seq_class;
    logic                 bad_seen;
    logic [1:0]           lead_count;
    logic                 bom_match;
    logic                 got_byte;

    // Verdicts owed for final transactions already accepted, oldest first.
    logic                 owed_verdicts[$];

    task automatic clear_decoder();
        cont_left  = 2'd0;
        code_point = '0;
        seq_class  = su8v_pkg::CLASS_NONE;
        bad_seen   = 1'b0;
        lead_count = 2'd0;
        bom_match  = 1'b1;
        got_byte   = 1'b0;
    endtask

    // Tracks whether the payload opens with the byte-order mark.
    task automatic follow_mark(input logic [7:0] value);
        logic [7:0] mark_byte;
        if (lead_count < 2'd3)
        begin
            case (lead_count)
                2'd0:    mark_byte = su8v_pkg::MARK_BYTE_0;
                2'd1:    mark_byte = su8v_pkg::MARK_BYTE_1;
                default: mark_byte = su8v_pkg::MARK_BYTE_2;
            endcase
            if (bom_match && value == mark_byte)
            begin
                if (lead_count == 2'd2)
                    bad_seen = 1'b1;
            end
            else
                bom_match = 1'b0;
            lead_count = lead_count + 2'd1;
        end
    endtask

    // A completed code point must not be overlong, beyond the last plane or a surrogate.
    task automatic judge_code_point();
        logic [CPW-1:0] floor_cp;
        case (seq_class)
            su8v_pkg::CLASS_2BYTE: floor_cp = su8v_pkg::MIN_CLASS_2BYTE;
            su8v_pkg::CLASS_3BYTE: floor_cp = su8v_pkg::MIN_CLASS_3BYTE;
            default:               floor_cp = su8v_pkg::MIN_CLASS_4BYTE;
        endcase
        if (code_point < floor_cp || code_point > su8v_pkg::MAX_CODE_POINT
            || (code_point >= su8v_pkg::SURROGATE_LOW
                && code_point <= su8v_pkg::SURROGATE_HIGH))
            bad_seen = 1'b1;
    endtask

    // Decodes one payload byte; nothing is decoded once an error has been seen.
    task automatic decode_byte(input logic [7:0] value);
        got_byte = 1'b1;
        follow_mark(value);
        if (!bad_seen)
        begin
            if (cont_left != 2'd0)
            begin
                if (value[7:6] != 2'b10)
                    bad_seen = 1'b1;
                else
                begin
                    code_point = {code_point[CPW-7:0], value[5:0]};
                    cont_left  = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                        judge_code_point();
                end
            end
            else if (value == 8'h00)
                bad_seen = 1'b1;
            else if (value >= su8v_pkg::LEAD2_LOW && value <= su8v_pkg::LEAD2_HIGH)
            begin
                cont_left  = 2'd1;
                code_point = CPW'(value[4:0]);
                seq_class  = su8v_pkg::CLASS_2BYTE;
            end
            else if (value >= su8v_pkg::LEAD3_LOW && value <= su8v_pkg::LEAD3_HIGH)
            begin
                cont_left  = 2'd2;
                code_point = CPW'(value[3:0]);
                seq_class  = su8v_pkg::CLASS_3BYTE;
            end
            else if (value >= su8v_pkg::LEAD4_LOW && value <= su8v_pkg::LEAD4_HIGH)
            begin
                cont_left  = 2'd3;
                code_point = CPW'(value[2:0]);
                seq_class  = su8v_pkg::CLASS_4BYTE;
            end
            else if (value > su8v_pkg::ASCII_HIGH)
                bad_seen = 1'b1;
        end
    endtask

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            clear_decoder();
            owed_verdicts.delete();
            fail_count = 0;
        end
        else
        begin
            // Verdict transaction: compare with the oldest verdict owed.
            if (verdict_valid && verdict_ready)
            begin
                if (owed_verdicts.size() == 0)
                    report_failure($sformatf("unexpected verdict transaction, payload_ok=%0b",
                                             payload_ok));
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (payload_ok !== want)
                        report_failure($sformatf("payload_ok mismatch: expected %0b, got %0b",
                                                 want, payload_ok));
                end
            end

            // Byte transaction: decode, and owe a verdict on the final one.
            if (byte_valid && byte_ready)
            begin
                if (byte_present)
                    decode_byte(data_byte);
                if (end_of_payload)
                begin
                    owed_verdicts.insert(owed_verdicts.size(),
                                         !bad_seen && got_byte && cont_left == 2'd0);
                    clear_decoder();
                end
            end
        end
        verdicts_waiting = owed_verdicts.size();
    end

endmodule

// ----- tb/tb_strict_utf8_validator_top.sv -----
`timescale 1ns / 100ps

module tb_strict_utf8_validator_top;

    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_GAP      = 5;
    localparam int LONG_HOLD    = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [7:0] octet_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       byte_valid     = 1'b0;
    logic       byte_ready;
    logic [7:0] data_byte      = 8'h00;
    logic       byte_present   = 1'b0;
    logic       end_of_payload = 1'b0;
    logic       verdict_valid;
    logic       verdict_ready  = 1'b0;
    logic       payload_ok;

    int fail_count;
    int verdicts_waiting;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    bit steady        = 1'b0;
    bit hold_verdicts = 1'b0;

    always #5 clk = ~clk;

    strict_utf8_validator_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_payload (end_of_payload),
        .verdict_valid  (verdict_valid),
        .verdict_ready  (verdict_ready),
        .payload_ok     (payload_ok)
    );

    strict_utf8_verdict_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_ready       (byte_ready),
        .data_byte        (data_byte),
        .byte_present     (byte_present),
        .end_of_payload   (end_of_payload),
        .verdict_valid    (verdict_valid),
        .verdict_ready    (verdict_ready),
        .payload_ok       (payload_ok),
        .fail_count       (fail_count),
        .verdicts_waiting (verdicts_waiting)
    );

    // Offers one byte transaction after a random gap and waits until it is taken.
    task automatic send_item(input octet_t value, input logic present, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid     <= 1'b1;
        data_byte      <= value;
        byte_present   <= present;
        end_of_payload <= last;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        if (present || last)
            items_sent++;
    endtask

    // Sends a payload, now and then with idle transactions in between and
    // sometimes closed by a marker-only transaction.
    task automatic send_payload(input octet_t bytes[$], input bit marker_tail);
        for (int i = 0; i < bytes.size(); i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(bytes[i], 1'b1, !marker_tail && i == bytes.size() - 1);
        end
        if (marker_tail || bytes.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Stops offering and waits until every verdict owed has been taken.
    task automatic drain_verdicts();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (verdicts_waiting != 0) @(negedge clk);
    endtask

    // Adds one byte at the end of a payload.
    task automatic append_octet(ref octet_t bytes[$], input octet_t value);
        bytes.insert(bytes.size(), value);
    endtask

    // Encodes a code point into the given number of bytes, overlong or not.
    task automatic push_coded(ref octet_t bytes[$], input logic [20:0] cp, input int len);
        case (len)
            1:
                append_octet(bytes, {1'b0, cp[6:0]});
            2:
            begin
                append_octet(bytes, {3'b110, cp[10:6]});
                append_octet(bytes, {2'b10, cp[5:0]});
            end
            3:
            begin
                append_octet(bytes, {4'b1110, cp[15:12]});
                append_octet(bytes, {2'b10, cp[11:6]});
                append_octet(bytes, {2'b10, cp[5:0]});
            end
            default:
            begin
                append_octet(bytes, {5'b11110, cp[20:18]});
                append_octet(bytes, {2'b10, cp[17:12]});
                append_octet(bytes, {2'b10, cp[11:6]});
                append_octet(bytes, {2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Appends one well-formed character of random length.
    task automatic push_char(ref octet_t bytes[$]);
        int          len;
        logic [20:0] cp;
        len = $urandom_range(1, 4);
        case (len)
            1: cp = 21'($urandom_range(1, 'h7f));
            2: cp = 21'($urandom_range('h80, 'h7ff));
            3:
            begin
                cp = 21'($urandom_range('h800, 'hffff));
                if (cp >= su8v_pkg::SURROGATE_LOW && cp <= su8v_pkg::SURROGATE_HIGH)
                    cp = cp ^ 21'h001000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10ffff));
        endcase
        push_coded(bytes, cp, len);
    endtask

    // Builds a random payload: mostly well-formed text, about a quarter of it
    // spoiled by one fault.
    task automatic build_payload(ref octet_t bytes[$], ref bit marker_tail);
        octet_t extra[$];
        int     fault;
        int     pos;
        int     len;
        bytes.delete();
        // Some payloads open with the first bytes of the mark and then depart from it.
        if ($urandom_range(0, 7) == 0)
            push_coded(bytes, 21'($urandom_range('hfec0, 'hfefe)), 3);
        repeat ($urandom_range(1, 6)) push_char(bytes);
        marker_tail = ($urandom_range(0, 3) == 0);
        fault = $urandom_range(0, 39);
        pos   = $urandom_range(0, bytes.size());
        case (fault)
            0:
                bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
            1:
            begin
                // A sequence cut short at the end of the payload.
                len = $urandom_range(2, 4);
                push_coded(bytes, 21'($urandom), len);
                repeat ($urandom_range(1, len - 1)) void'(bytes.pop_back());
            end
            2:
            begin
                len = $urandom_range(2, 4);
                case (len)
                    2:       push_coded(extra, 21'($urandom_range(0, 'h7f)), 2);
                    3:       push_coded(extra, 21'($urandom_range(0, 'h7ff)), 3);
                    default: push_coded(extra, 21'($urandom_range(0, 'hffff)), 4);
                endcase
            end
            3:
                push_coded(extra,
                           21'($urandom_range(su8v_pkg::SURROGATE_LOW,
                                              su8v_pkg::SURROGATE_HIGH)),
                           3);
            4:
                push_coded(extra, 21'($urandom_range('h110000, 'h1fffff)), 4);
            5:
                append_octet(extra, 8'h00);
            6:
            begin
                if ($urandom_range(0, 2) == 0)
                    bytes.delete();
                pos   = 0;
                extra = {su8v_pkg::MARK_BYTE_0, su8v_pkg::MARK_BYTE_1, su8v_pkg::MARK_BYTE_2};
            end
            7:
                bytes.delete();
            8:
            begin
                case ($urandom_range(0, 2))
                    0:       append_octet(extra, 8'($urandom_range('hc0, 'hc1)));
                    1:       append_octet(extra, 8'($urandom_range('h80, 'hbf)));
                    default: append_octet(extra, 8'($urandom_range('hf5, 'hff)));
                endcase
            end
            9:
            begin
                bytes.delete();
                repeat ($urandom_range(1, 6)) append_octet(bytes, 8'($urandom_range(0, 255)));
            end
            default:
                ;
        endcase
        for (int i = 0; i < extra.size(); i++)
            bytes.insert(pos + i, extra[i]);
    endtask

    // Verdict side: a random stall before each transaction, or one long
    // hold-off when asked for.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_verdicts)
            begin
                stall         = LONG_HOLD;
                hold_verdicts = 1'b0;
            end
            else
                stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                verdict_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            verdict_ready <= 1'b1;
            @(posedge clk);
            while (!verdict_valid) @(posedge clk);
        end
    end

    // Watchdog: too long without any transaction on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (verdict_valid && verdict_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus.
    initial
    begin
        octet_t msg[$];
        bit     marker_tail;
        int     payloads;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty payload: a marker with no bytes.
        msg.delete();
        send_payload(msg, 1'b0);
        // An idle transaction is ignored; the highest single-byte character is fine.
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h7f, 1'b1, 1'b1);
        // NUL byte.
        send_item(8'h00, 1'b1, 1'b1);
        // Smallest two-byte character.
        msg = {8'hc2, 8'h80};
        send_payload(msg, 1'b0);
        // Lead byte below the legal range; the continuation after the error is not decoded.
        msg = {8'hc1, 8'h80};
        send_payload(msg, 1'b0);
        // Overlong three-byte sequence.
        msg = {8'he0, 8'h80, 8'h80};
        send_payload(msg, 1'b0);
        // Surrogate.
        msg = {8'hed, 8'ha0, 8'h80};
        send_payload(msg, 1'b0);
        // Code point above the last plane.
        msg = {8'hf4, 8'h90, 8'h80, 8'h80};
        send_payload(msg, 1'b0);
        // Malformed continuation byte.
        msg = {8'hc2, 8'h41};
        send_payload(msg, 1'b0);
        // Payload ending inside a sequence, closed by a marker-only transaction.
        msg = {8'he2, 8'h82};
        send_payload(msg, 1'b1);
        // Byte-order mark followed by more text.
        msg = {su8v_pkg::MARK_BYTE_0, su8v_pkg::MARK_BYTE_1, su8v_pkg::MARK_BYTE_2, 8'h41};
        send_payload(msg, 1'b0);
        drain_verdicts();

        // Random payloads, with one long verdict hold-off and periodic full drains.
        items_sent = 0;
        payloads   = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            payloads++;
            steady = ($urandom_range(0, 4) == 0);
            if (payloads == 40)
            begin
                steady        = 1'b1;
                hold_verdicts = 1'b1;
            end
            if (payloads % 75 == 0)
                drain_verdicts();
            build_payload(msg, marker_tail);
            send_payload(msg, marker_tail);
        end

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/su8v_pkg.sv
src/strict_utf8_validator_top.sv
tb/strict_utf8_verdict_checker.sv
tb/tb_strict_utf8_validator_top.sv
